[hdl/s3mpu_pkg.sv]
package s3mpu_pkg;

  // Rows in one pattern; the row counter wraps after the last one.
  localparam int RowsPerPattern = 64;
  localparam int RowCntW = (RowsPerPattern > 1) ? $clog2(RowsPerPattern) : 1;

  // Depth of the result queue between the parser and the output side.
  localparam int QueueDepth = 2;
  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] FieldAbsent = 8'd255;
  localparam logic [7:0] VolumeMax = 8'd64;

  typedef enum logic {
    KIND_CELL    = 1'b0,
    KIND_ROW_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] row;
    logic [4:0] channel;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] effect_param;
    logic       pattern_done;
  } result_t;

endpackage

[hdl/s3mpu_front.sv]
module s3mpu_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [31:0]           cfg_data,
  input  logic                  accept,
  input  logic [7:0]            pattern_byte,
  output logic                  emit,
  output s3mpu_pkg::result_t    result
);
  import s3mpu_pkg::*;

  typedef enum logic [5:0] {
    PH_FLAG  = 6'b000001,
    PH_NOTE  = 6'b000010,
    PH_INSTR = 6'b000100,
    PH_VOL   = 6'b001000,
    PH_EFF   = 6'b010000,
    PH_PARAM = 6'b100000
  } phase_t;

  phase_t              phase;
  phase_t              phase_next;
  logic                entry_done;
  logic [31:0]         channel_enabled;
  logic [7:0]          held_flag;
  logic [RowCntW-1:0]  row_count;
  logic [7:0]          held_note;
  logic [7:0]          held_instrument;
  logic [7:0]          held_volume;
  logic [7:0]          held_effect;

  logic                at_flag;
  logic                row_end;
  logic                last_row;
  logic [7:0]          flag;
  logic [7:0]          cur_note;
  logic [7:0]          cur_instrument;
  logic [7:0]          cur_volume;
  logic [7:0]          cur_effect;
  logic [7:0]          cur_param;
  logic [7:0]          clamped;
  logic [8:0]          row_wide;

  // Any code that is not one of the phases counts as waiting for a flag byte.
  always_comb begin
    at_flag = (phase == PH_FLAG) || !(phase == PH_NOTE || phase == PH_INSTR ||
              phase == PH_VOL || phase == PH_EFF || phase == PH_PARAM);
  end

  assign flag     = at_flag ? pattern_byte : held_flag;
  assign row_end  = at_flag && (pattern_byte == 8'd0);
  assign last_row = (row_count == RowCntW'(RowsPerPattern - 1));
  assign clamped  = (pattern_byte > VolumeMax) ? VolumeMax : pattern_byte;
  assign row_wide = 9'(row_count);

  assign cur_note       = at_flag ? FieldAbsent :
                          (phase == PH_NOTE) ? pattern_byte : held_note;
  assign cur_instrument = at_flag ? FieldAbsent :
                          (phase == PH_INSTR) ? pattern_byte : held_instrument;
  assign cur_volume     = at_flag ? FieldAbsent :
                          (phase == PH_VOL) ? clamped : held_volume;
  assign cur_effect     = at_flag ? FieldAbsent :
                          (phase == PH_EFF) ? pattern_byte : held_effect;
  assign cur_param      = (!at_flag && phase == PH_PARAM) ? pattern_byte : FieldAbsent;

  // Next point in the entry, driven by the announce bits of the flag.
  always_comb begin
    phase_next = PH_FLAG;
    entry_done = 1'b0;
    if (at_flag && flag[5]) begin
      phase_next = PH_NOTE;
    end else if (!at_flag && phase == PH_NOTE) begin
      phase_next = PH_INSTR;
    end else if ((at_flag || phase == PH_INSTR) && flag[6]) begin
      phase_next = PH_VOL;
    end else if ((at_flag || phase == PH_INSTR || phase == PH_VOL) && flag[7]) begin
      phase_next = PH_EFF;
    end else if (!at_flag && phase == PH_EFF) begin
      phase_next = PH_PARAM;
    end else begin
      entry_done = 1'b1;
    end
  end

  always_comb begin
    result = '0;
    result.row = row_wide[5:0];
    if (row_end) begin
      result.kind = KIND_ROW_END;
      result.pattern_done = last_row;
      emit = accept;
    end else begin
      result.kind         = KIND_CELL;
      result.channel      = flag[4:0];
      result.note         = cur_note;
      result.instrument   = cur_instrument;
      result.volume       = cur_volume;
      result.effect       = cur_effect;
      result.effect_param = cur_param;
      emit = accept && entry_done && channel_enabled[flag[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FLAG;
      channel_enabled <= '1;
      held_flag       <= '0;
      row_count       <= '0;
      held_note       <= FieldAbsent;
      held_instrument <= FieldAbsent;
      held_volume     <= FieldAbsent;
      held_effect     <= FieldAbsent;
    end else begin
      if (cfg_write) begin
        channel_enabled <= cfg_data;
      end
      if (accept) begin
        if (row_end) begin
          phase     <= PH_FLAG;
          row_count <= last_row ? '0 : row_count + RowCntW'(1);
        end else begin
          held_flag       <= flag;
          held_note       <= cur_note;
          held_instrument <= cur_instrument;
          held_volume     <= cur_volume;
          held_effect     <= cur_effect;
          phase           <= phase_next;
        end
      end
    end
  end

  a_row_end_zero : assert property (@(posedge clk) disable iff (rst)
    (emit && result.kind == KIND_ROW_END) |-> (pattern_byte == 8'd0))
    else $error("row end emitted for a nonzero byte");

  a_done_on_row_end : assert property (@(posedge clk) disable iff (rst)
    (emit && result.pattern_done) |-> (result.kind == KIND_ROW_END))
    else $error("pattern done flagged on a cell");

  a_flag_held : assert property (@(posedge clk) disable iff (rst)
    (accept && at_flag && pattern_byte != 8'd0) |=> (held_flag == $past(pattern_byte)))
    else $error("flag byte not captured");

endmodule

[hdl/s3mpu_queue.sv]
module s3mpu_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  s3mpu_pkg::result_t    push_data,
  output logic                  full,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output s3mpu_pkg::result_t    pop_data
);
  import s3mpu_pkg::*;

  result_t           slots [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;
  logic              pop;

  assign full      = (count == QCntW'(QueueDepth));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_pop_count : assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - QCntW'(1)))
    else $error("queue count did not drop on pop");

endmodule

[hdl/s3m_packed_pattern_unpacker.sv]
// Unpacks the packed pattern data of an S3M module, one stream byte per beat on
// the input channel. In the flag position a zero byte ends the row and yields a
// row-end result (kind 1) carrying the row number; pattern_done is set on the
// row end of the last row, after which the row count starts again at 0. A
// nonzero flag names a source channel in its low five bits and announces note
// and instrument (bit 5), volume (bit 6) and effect with parameter (bit 7);
// once the last announced byte is in, a cell result (kind 0) is produced if the
// channel's bit in channel_enabled is set. Absent fields read 255, volume is
// clamped to 64, and the unused fields of a row end read 0. channel_enabled is
// written through the configuration channel (always ready) and resets to all
// ones; write it only while the block is idle.
// Rate: one byte per cycle while the result queue has a free slot; each result
// is registered in that queue before it reaches the output. The parser decides
// each byte in the cycle it arrives and pushes any result into a two-entry
// queue; input ready drops only while that queue is full. When every byte
// yields a result the queue sits at one entry, so an output stall fills it and
// holds the stream; with sparser results the free slot absorbs a short stall.
module s3m_packed_pattern_unpacker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] channel_enabled,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pattern_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [5:0]  row,
  output logic [4:0]  channel,
  output logic [7:0]  note,
  output logic [7:0]  instrument,
  output logic [7:0]  volume,
  output logic [7:0]  effect,
  output logic [7:0]  effect_param,
  output logic        pattern_done
);
  import s3mpu_pkg::*;

  logic    accept;
  logic    emit;
  logic    q_full;
  result_t front_result;
  result_t head;

  // The configuration register lives in the parser and is never busy.
  assign cfg_ready = 1'b1;

  // A byte may produce at most one result, so a free slot is all it needs.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  s3mpu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (channel_enabled),
    .accept       (accept),
    .pattern_byte (pattern_byte),
    .emit         (emit),
    .result       (front_result)
  );

  s3mpu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (front_result),
    .full      (q_full),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (head)
  );

  assign kind         = head.kind;
  assign row          = head.row;
  assign channel      = head.channel;
  assign note         = head.note;
  assign instrument   = head.instrument;
  assign volume       = head.volume;
  assign effect       = head.effect;
  assign effect_param = head.effect_param;
  assign pattern_done = head.pattern_done;

endmodule
